[rtl/spdpid_pkg.sv]
`default_nettype none

package spdpid_pkg;

    localparam int TABLE_POINTS = 10;
    localparam int TBL_IW       = $clog2(TABLE_POINTS);

    // Q8.8 x Q8.8 product back to whole percent, and the Q0.8 / fraction scale
    localparam int QDIV     = 65536;
    localparam int FRAC_DIV = 256;

    localparam logic signed [7:0] FF_TABLE [32] = '{
        8'sd33, 8'sd33, 8'sd33, 8'sd34, 8'sd35, 8'sd38, 8'sd39, 8'sd40,
        8'sd41, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42,
        8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42,
        8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42, 8'sd42
    };

    typedef enum logic [2:0] {
        CFG_GAINS_NORMAL    = 3'd0,
        CFG_GAINS_OVERSPEED = 3'd1,
        CFG_GAINS_FULL_STOP = 3'd2,
        CFG_DEAD_BAND       = 3'd3,
        CFG_INTEGRAL_BAND   = 3'd4,
        CFG_INTEGRAL_LIMIT  = 3'd5,
        CFG_TORQUE_BOUNDS   = 3'd6,
        CFG_INTEGRAL_DECAY  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic signed [15:0] kd;
    } t_gains;

    typedef struct packed {
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
    } t_in;

    typedef struct packed {
        logic signed [7:0]  torque_request;
        logic signed [15:0] p_part;
        logic signed [7:0]  i_part;
        logic signed [15:0] d_part;
        logic signed [7:0]  ff_part;
    } t_out;

    function automatic logic signed [7:0] ff_entry(input logic [4:0] idx);
        return FF_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

[rtl/spdpid_ff.sv]
`default_nettype none

module spdpid_ff (
    input  wire logic signed [15:0] i_target_speed,
    output logic signed [7:0]       o_ff_part
);

    logic                           w_pos;
    logic [7:0]                     w_k_raw;
    logic [spdpid_pkg::TBL_IW-1:0]  w_k;
    logic [spdpid_pkg::TBL_IW-1:0]  w_k1;
    logic [7:0]                     w_f;
    logic [8:0]                     w_wl;
    logic signed [7:0]              w_t0;
    logic signed [7:0]              w_t1;
    logic signed [17:0]             w_lo;
    logic signed [17:0]             w_hi;
    logic signed [18:0]             w_sum;

    always_comb begin
        w_pos   = !i_target_speed[15] && (i_target_speed != 16'sd0);
        w_k_raw = i_target_speed[15:8];
        // past the end of the table: keep interpolating between the last two points
        if (w_k_raw > 8'(spdpid_pkg::TABLE_POINTS - 2)) begin
            w_k = spdpid_pkg::TBL_IW'(spdpid_pkg::TABLE_POINTS - 2);
        end else begin
            w_k = spdpid_pkg::TBL_IW'(w_k_raw);
        end
        w_k1  = w_k + 1'b1;
        w_f   = i_target_speed[7:0];
        w_wl  = 9'd256 - {1'b0, w_f};
        w_t0  = spdpid_pkg::ff_entry(5'(w_k));
        w_t1  = spdpid_pkg::ff_entry(5'(w_k1));
        w_lo  = $signed({1'b0, w_wl}) * w_t0;
        w_hi  = $signed({2'b00, w_f}) * w_t1;
        w_sum = 19'(w_lo) + 19'(w_hi);
        if (w_pos) begin
            o_ff_part = 8'(w_sum / spdpid_pkg::FRAC_DIV);
        end else begin
            o_ff_part = 8'sd0;
        end
    end

endmodule

`default_nettype wire

[rtl/speed_pid_feedforward_torque.sv]
// Stages: an accepted request waits in the input register; its result is computed
// combinationally and registered into the output register when that stage advances.
// Throughput: one request per cycle while the output is not stalled; all loop state
// (previous error, integral, held parts) is updated in the single pass from the input
// register to the result register. Reset (synchronous, active low): loop state cleared
// to zero, both stages emptied, configuration registers back to their defaults.
`default_nettype none

module speed_pid_feedforward_torque (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire spdpid_pkg::t_in  i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output spdpid_pkg::t_out      o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [47:0]      i_cfg_data
);

    // configuration
    spdpid_pkg::t_gains r_g_normal;
    spdpid_pkg::t_gains r_g_over;
    spdpid_pkg::t_gains r_g_stop;
    logic [15:0]        r_dead_band;
    logic [15:0]        r_int_band;
    logic [6:0]         r_int_lim;
    logic [23:0]        r_bounds;
    logic [7:0]         r_decay;

    // loop state
    logic signed [17:0] r_prev_err;
    logic signed [23:0] r_integ;
    logic signed [15:0] r_held_p;
    logic signed [7:0]  r_held_i;
    logic signed [15:0] r_held_d;

    // stages
    logic               r_s1_valid;
    spdpid_pkg::t_in    r_s1;
    logic               r_out_valid;
    spdpid_pkg::t_out   r_out;

    logic               w_s1_go;

    logic signed [15:0] w_tgt;
    logic signed [15:0] w_meas;
    logic signed [17:0] w_err;
    logic signed [17:0] w_derr;
    logic [17:0]        w_abs_err;
    logic signed [18:0] w_err_p_db;
    logic signed [24:0] w_integ_sum;
    logic signed [23:0] w_integ_sat;
    logic               w_standstill;
    logic               w_in_db;
    logic               w_stopping;
    logic               w_overspeed;
    logic               w_low_speed;
    logic               w_out_band;
    spdpid_pkg::t_gains w_g;
    logic signed [33:0] w_p_prod;
    logic signed [33:0] w_p_q;
    logic signed [39:0] w_i_prod;
    logic signed [39:0] w_i_q;
    logic signed [33:0] w_d_prod;
    logic signed [33:0] w_d_q;
    logic signed [32:0] w_integ_dec;
    logic signed [16:0] w_hi_dec;
    logic signed [15:0] w_p;
    logic signed [15:0] w_d;
    logic signed [23:0] w_i_pre;
    logic signed [23:0] w_lim24;
    logic signed [7:0]  w_i;
    logic signed [23:0] w_integ_next;
    logic signed [7:0]  w_ff;
    logic signed [17:0] w_total;
    logic signed [7:0]  w_tmax;
    logic signed [7:0]  w_tmin;
    logic signed [7:0]  w_hold;
    logic signed [7:0]  w_torque;
    logic signed [7:0]  w_ff_sel;
    spdpid_pkg::t_out   w_res;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    assign w_s1_go     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || w_s1_go;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    spdpid_ff u_ff (
        .i_target_speed (r_s1.target_speed),
        .o_ff_part      (w_ff)
    );

    always_comb begin
        w_meas = r_s1.measured_speed;
        w_tgt  = (r_s1.target_speed[15] || (r_s1.target_speed == 16'sd0)) ?
                 16'sd0 : r_s1.target_speed;
        w_err  = 18'(w_tgt) - 18'(w_meas);
        w_derr = w_err - r_prev_err;
        w_abs_err  = w_err[17] ? 18'(-w_err) : 18'(w_err);
        w_err_p_db = 19'(w_err) + $signed({3'b000, r_dead_band});

        w_integ_sum = 25'(r_integ) + 25'(w_err);
        if (w_integ_sum > 25'sd8388607) begin
            w_integ_sat = 24'sh7FFFFF;
        end else if (w_integ_sum < -25'sd8388608) begin
            w_integ_sat = 24'sh800000;
        end else begin
            w_integ_sat = 24'(w_integ_sum);
        end

        w_standstill = (w_tgt == 16'sd0) && (w_meas == 16'sd0);
        w_in_db      = w_abs_err < {2'b00, r_dead_band};
        w_stopping   = (w_tgt == 16'sd0) && !w_meas[15] && (w_meas != 16'sd0);
        w_overspeed  = w_err_p_db[18];
        w_low_speed  = 17'(w_meas) < $signed({1'b0, r_dead_band});
        w_out_band   = w_abs_err > {2'b00, r_int_band};

        if (w_stopping) begin
            w_g = r_g_stop;
        end else if (w_overspeed) begin
            w_g = r_g_over;
        end else begin
            w_g = r_g_normal;
        end

        w_p_prod = w_err * $signed(w_g.kp);
        w_p_q    = w_p_prod / spdpid_pkg::QDIV;
        w_i_prod = w_integ_sat * $signed(w_g.ki);
        w_i_q    = w_i_prod / spdpid_pkg::QDIV;
        w_d_prod = w_derr * $signed(w_g.kd);
        w_d_q    = w_d_prod / spdpid_pkg::QDIV;

        w_integ_dec = w_integ_sat * $signed({1'b0, r_decay});
        w_hi_dec    = r_held_i * $signed({1'b0, r_decay});

        w_integ_next = w_integ_sat;
        if (w_standstill) begin
            w_p     = 16'sd0;
            w_d     = 16'sd0;
            w_i_pre = 24'sd0;
        end else if (w_in_db) begin
            // hold P and D, let the integral bleed off
            w_p          = r_held_p;
            w_d          = r_held_d;
            w_i_pre      = 24'(8'(w_hi_dec / spdpid_pkg::FRAC_DIV));
            w_integ_next = 24'(w_integ_dec / spdpid_pkg::FRAC_DIV);
        end else begin
            w_p     = sat16(18'(w_p_q));
            w_d     = sat16(18'(w_d_q));
            w_i_pre = 24'(w_i_q);
        end

        w_lim24 = $signed({17'd0, r_int_lim});
        if (w_i_pre > w_lim24) begin
            w_i = $signed({1'b0, r_int_lim});
        end else if (w_i_pre < -w_lim24) begin
            w_i = -$signed({1'b0, r_int_lim});
        end else begin
            w_i = 8'(w_i_pre);
        end
        if (w_low_speed) begin
            w_i = 8'sd0;
        end
        if (w_out_band) begin
            w_i          = 8'sd0;
            w_integ_next = 24'sd0;
        end

        w_tmax   = $signed(r_bounds[23:16]);
        w_tmin   = $signed(r_bounds[15:8]);
        w_hold   = $signed(r_bounds[7:0]);
        w_ff_sel = w_standstill ? w_hold : w_ff;
        w_total  = 18'(w_p) + 18'(w_i) + 18'(w_d) + 18'(w_ff_sel);
        if (w_total > 18'(w_tmax)) begin
            w_torque = w_tmax;
        end else if (w_total < 18'(w_tmin)) begin
            w_torque = w_tmin;
        end else begin
            w_torque = 8'(w_total);
        end

        w_res.torque_request = w_torque;
        w_res.p_part         = w_p;
        w_res.i_part         = w_i;
        w_res.d_part         = w_d;
        w_res.ff_part        = w_ff_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_normal  <= '0;
            r_g_over    <= '0;
            r_g_stop    <= '0;
            r_dead_band <= 16'd26;
            r_int_band  <= 16'd256;
            r_int_lim   <= 7'd20;
            r_bounds    <= 24'h649C00;
            r_decay     <= 8'd250;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spdpid_pkg::CFG_GAINS_NORMAL:    r_g_normal  <= i_cfg_data;
                spdpid_pkg::CFG_GAINS_OVERSPEED: r_g_over    <= i_cfg_data;
                spdpid_pkg::CFG_GAINS_FULL_STOP: r_g_stop    <= i_cfg_data;
                spdpid_pkg::CFG_DEAD_BAND:       r_dead_band <= i_cfg_data[15:0];
                spdpid_pkg::CFG_INTEGRAL_BAND:   r_int_band  <= i_cfg_data[15:0];
                spdpid_pkg::CFG_INTEGRAL_LIMIT:  r_int_lim   <= i_cfg_data[6:0];
                spdpid_pkg::CFG_TORQUE_BOUNDS:   r_bounds    <= i_cfg_data[23:0];
                spdpid_pkg::CFG_INTEGRAL_DECAY:  r_decay     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_err  <= '0;
            r_integ     <= '0;
            r_held_p    <= '0;
            r_held_i    <= '0;
            r_held_d    <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_s1_go) begin
                r_out_valid <= 1'b1;
                r_prev_err  <= w_err;
                r_integ     <= w_integ_next;
                r_held_p    <= w_p;
                r_held_i    <= w_i;
                r_held_d    <= w_d;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (w_s1_go) begin
            r_out <= w_res;
        end
    end

`ifndef NO_ASSERTIONS
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_go |=> ($stable(r_integ) && $stable(r_prev_err) && $stable(r_held_i)))
        else $error("loop state changed without a request advancing");

    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_go) |=> r_s1_valid)
        else $error("pending request dropped from input stage");

    a_i_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.i_part <= $signed({1'b0, r_int_lim})) &&
                         (o_out_data.i_part >= -$signed({1'b0, r_int_lim}))))
        else $error("integral part outside its limit");

    a_torque_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (w_tmax >= w_tmin)) |->
            ((o_out_data.torque_request <= w_tmax) &&
             (o_out_data.torque_request >= w_tmin)))
        else $error("torque request outside its bounds");
`endif

endmodule

`default_nettype wire
